FILE: sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and character codes for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_BODY      = 4'd1,
    PH_ESC       = 4'd2,
    PH_HEX       = 4'd3,
    PH_SURR_WAIT = 4'd4,
    PH_SURR_U    = 4'd5,
    PH_LOHEX     = 4'd6
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NO_QUOTE   = 2'd0;
  localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
  localparam logic [1:0] ERR_EARLY_END  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] SURR_HIGH_LO = 16'hd800;
  localparam logic [15:0] SURR_LOW_LO  = 16'hdc00;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] acc;
    logic [15:0] high;
    logic [2:0]  hcnt;
  } jsu_state_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [2:0]                       cnt;
    logic [MAX_RESULTS-1:0][1:0]      kinds;
    logic [MAX_RESULTS-1:0][7:0]      bytes;
    logic [15:0]                      len;
    logic [1:0]                       err;
  } jsu_bundle_t;

endpackage

FILE: sv/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string literal, one text byte per request, into UTF-8 bytes.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle, when not stalled, into an input
// register, decodes it in a single pass and loads all its results (up to
// four) into a result register; they leave it one per cycle while out_stall
// is low. A byte that causes at most one result therefore flows at one byte
// per clock while the output is not stalled; a byte with n results holds the
// result register until all n have left, and the input stalls only while it
// drains. The decoded length counter saturates at 2^LENGTH_WIDTH - 1.
module json_string_unescape_utf8 #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [15:0] string_length,
  output logic [1:0]  error_code,
  output logic        last_of_run
);

  logic                    in_full;
  logic [7:0]              in_byte;
  jsu_pkg::jsu_state_t     st;
  jsu_pkg::jsu_state_t     st_next;
  logic [LENGTH_WIDTH-1:0] len;
  logic [LENGTH_WIDTH-1:0] len_next;
  jsu_pkg::jsu_bundle_t    res;
  jsu_pkg::jsu_bundle_t    res_next;
  logic                    res_full;
  logic [1:0]              idx;
  logic                    last;
  logic                    res_free;
  logic                    move;
  logic                    in_take;

  jsu_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .st        (st),
    .len       (len),
    .char_byte (in_byte),
    .st_next   (st_next),
    .len_next  (len_next),
    .bundle    (res_next)
  );

  assign last     = (idx == 2'(res.cnt - 3'd1));
  assign res_free = !res_full || (!out_stall && last);
  // a byte with no results never waits on the result register
  assign move     = in_full && (res_next.cnt == 3'd0 || res_free);
  assign in_stall = in_full && !move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      res_full <= 1'b0;
      idx      <= 2'd0;
      st       <= '{phase: jsu_pkg::PH_IDLE, acc: 16'h0, high: 16'h0, hcnt: 3'd0};
      len      <= '0;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
        in_byte <= char_byte;
      end else if (move) begin
        in_full <= 1'b0;
      end

      // a new bundle only loads when the old one is gone or leaving
      if (move && res_next.cnt != 3'd0) begin
        res      <= res_next;
        res_full <= 1'b1;
        idx      <= 2'd0;
      end else if (res_full && !out_stall) begin
        if (last) begin
          res_full <= 1'b0;
          idx      <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end

      if (move) begin
        st  <= st_next;
        len <= len_next;
      end
    end
  end

  assign out_valid     = res_full;
  assign kind          = res.kinds[idx];
  assign out_byte      = (kind == jsu_pkg::KIND_BYTE) ? res.bytes[idx] : 8'h00;
  assign string_length = (kind == jsu_pkg::KIND_DONE) ? res.len : 16'h0;
  assign error_code    = (kind == jsu_pkg::KIND_ERROR) ? res.err : 2'd0;
  assign last_of_run   = last;

endmodule

FILE: sv/jsu_step.sv
// ----------------------------------------------------------------------------
// jsu_step
// Single-pass decode of one text byte: next parser state plus the bundle
// of up to four results that the byte causes.
// ----------------------------------------------------------------------------
module jsu_step #(
  parameter int LENGTH_WIDTH = 16
) (
  input  jsu_pkg::jsu_state_t       st,
  input  logic [LENGTH_WIDTH-1:0]   len,
  input  logic [7:0]                char_byte,
  output jsu_pkg::jsu_state_t       st_next,
  output logic [LENGTH_WIDTH-1:0]   len_next,
  output jsu_pkg::jsu_bundle_t      bundle
);

  typedef struct packed {
    logic             v;
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [1:0]       err;
    jsu_pkg::phase_t  phase;
  } tail_t;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][7:0]  b;
  } utf8_t;

  function automatic logic [3:0] nibble(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
    return d[3:0];
  endfunction

  function automatic utf8_t utf8_enc(logic [31:0] cp);
    utf8_t u;
    logic [31:0] t0, t1, t2, t3;
    u = '0;
    t0 = 32'h0;
    t1 = 32'h0;
    t2 = 32'h0;
    t3 = 32'h0;
    if (cp < 32'h80) begin
      u.n = 3'd1;
      t0 = cp;
    end else if (cp < 32'h800) begin
      u.n = 3'd2;
      t0 = 32'hc0 | (cp >> 6);
      t1 = 32'h80 | (cp & 32'h3f);
    end else if (cp < 32'h10000) begin
      u.n = 3'd3;
      t0 = 32'he0 | (cp >> 12);
      t1 = 32'h80 | ((cp >> 6) & 32'h3f);
      t2 = 32'h80 | (cp & 32'h3f);
    end else begin
      u.n = 3'd4;
      t0 = 32'hf0 | (cp >> 18);
      t1 = 32'h80 | ((cp >> 12) & 32'h3f);
      t2 = 32'h80 | ((cp >> 6) & 32'h3f);
      t3 = 32'h80 | (cp & 32'h3f);
    end
    u.b[0] = t0[7:0];
    u.b[1] = t1[7:0];
    u.b[2] = t2[7:0];
    u.b[3] = t3[7:0];
    return u;
  endfunction

  function automatic tail_t body_tail(logic [7:0] c);
    tail_t t;
    t = '0;
    t.phase = jsu_pkg::PH_BODY;
    if (c == jsu_pkg::CH_NUL) begin
      t.v = 1'b1;
      t.kind = jsu_pkg::KIND_ERROR;
      t.err = jsu_pkg::ERR_EARLY_END;
      t.phase = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_QUOTE) begin
      t.v = 1'b1;
      t.kind = jsu_pkg::KIND_DONE;
      t.phase = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_BSL) begin
      t.phase = jsu_pkg::PH_ESC;
    end else begin
      t.v = 1'b1;
      t.kind = jsu_pkg::KIND_BYTE;
      t.data = c;
    end
    return t;
  endfunction

  function automatic tail_t esc_tail(logic [7:0] c);
    tail_t t;
    t = '0;
    t.v = 1'b1;
    t.kind = jsu_pkg::KIND_BYTE;
    t.phase = jsu_pkg::PH_BODY;
    case (c)
      8'h6e: t.data = 8'h0a;
      8'h74: t.data = 8'h09;
      8'h72: t.data = 8'h0d;
      8'h62: t.data = 8'h08;
      8'h66: t.data = 8'h0c;
      jsu_pkg::CH_SLASH: t.data = jsu_pkg::CH_SLASH;
      jsu_pkg::CH_QUOTE: t.data = jsu_pkg::CH_QUOTE;
      jsu_pkg::CH_BSL:   t.data = jsu_pkg::CH_BSL;
      jsu_pkg::CH_U: begin
        t.v = 1'b0;
        t.phase = jsu_pkg::PH_HEX;
      end
      default: begin
        t.kind = jsu_pkg::KIND_ERROR;
        t.err = jsu_pkg::ERR_BAD_ESCAPE;
        t.phase = jsu_pkg::PH_IDLE;
      end
    endcase
    return t;
  endfunction

  function automatic logic [LENGTH_WIDTH-1:0] sat_add(logic [LENGTH_WIDTH-1:0] a,
                                                      logic [2:0] n);
    logic [LENGTH_WIDTH:0] s;
    s = {1'b0, a} + (LENGTH_WIDTH+1)'(n);
    return s[LENGTH_WIDTH] ? '1 : s[LENGTH_WIDTH-1:0];
  endfunction

  tail_t                   tail;
  utf8_t                   pre;
  logic [15:0]             acc_n;
  logic [2:0]              cnt_n;
  logic [31:0]             cp;
  logic                    open_quote;
  logic [2:0]              tail_bytes;
  logic [LENGTH_WIDTH-1:0] len_done;
  logic [31:0]             len_wide;

  always_comb begin
    st_next    = st;
    tail       = '0;
    tail.phase = st.phase;
    pre        = '0;
    open_quote = 1'b0;
    acc_n      = {st.acc[11:0], nibble(char_byte)};
    cnt_n      = st.hcnt + 3'd1;
    // joined surrogate pair, wraps modulo 2^32
    cp = 32'h10000 + (({16'h0, st.high} - {16'h0, jsu_pkg::SURR_HIGH_LO}) << 10)
         + ({16'h0, acc_n} - {16'h0, jsu_pkg::SURR_LOW_LO});

    case (st.phase)
      jsu_pkg::PH_IDLE: begin
        if (char_byte == jsu_pkg::CH_QUOTE) begin
          open_quote = 1'b1;
          tail.phase = jsu_pkg::PH_BODY;
          st_next.acc = 16'h0;
          st_next.high = 16'h0;
          st_next.hcnt = 3'd0;
        end else begin
          tail.v = 1'b1;
          tail.kind = jsu_pkg::KIND_ERROR;
          tail.err = jsu_pkg::ERR_NO_QUOTE;
          tail.phase = jsu_pkg::PH_IDLE;
        end
      end
      jsu_pkg::PH_BODY: tail = body_tail(char_byte);
      jsu_pkg::PH_ESC:  tail = esc_tail(char_byte);
      jsu_pkg::PH_HEX, jsu_pkg::PH_LOHEX: begin
        if (char_byte == jsu_pkg::CH_NUL) begin
          tail.v = 1'b1;
          tail.kind = jsu_pkg::KIND_ERROR;
          tail.err = jsu_pkg::ERR_EARLY_END;
          tail.phase = jsu_pkg::PH_IDLE;
        end else begin
          st_next.acc = acc_n;
          st_next.hcnt = cnt_n;
          if (cnt_n == 3'd4) begin
            st_next.hcnt = 3'd0;
            tail.phase = jsu_pkg::PH_BODY;
            if (st.phase == jsu_pkg::PH_LOHEX) begin
              pre = utf8_enc(cp);
            end else if (acc_n >= jsu_pkg::SURR_HIGH_LO && acc_n < jsu_pkg::SURR_LOW_LO) begin
              st_next.high = acc_n;
              tail.phase = jsu_pkg::PH_SURR_WAIT;
            end else begin
              pre = utf8_enc({16'h0, acc_n});
            end
          end
        end
      end
      jsu_pkg::PH_SURR_WAIT: begin
        if (char_byte == jsu_pkg::CH_BSL) begin
          tail.phase = jsu_pkg::PH_SURR_U;
        end else begin
          // lone high surrogate, then the byte handled as string body
          pre = utf8_enc({16'h0, st.high});
          tail = body_tail(char_byte);
        end
      end
      jsu_pkg::PH_SURR_U: begin
        if (char_byte == jsu_pkg::CH_U) begin
          tail.phase = jsu_pkg::PH_LOHEX;
          st_next.acc = 16'h0;
          st_next.hcnt = 3'd0;
        end else begin
          pre = utf8_enc({16'h0, st.high});
          tail = esc_tail(char_byte);
        end
      end
      default: begin
        tail.v = 1'b1;
        tail.kind = jsu_pkg::KIND_ERROR;
        tail.err = jsu_pkg::ERR_NO_QUOTE;
        tail.phase = jsu_pkg::PH_IDLE;
      end
    endcase

    // escape start clears the digit collector
    if (tail.phase == jsu_pkg::PH_HEX && st.phase != jsu_pkg::PH_HEX) begin
      st_next.acc = 16'h0;
      st_next.hcnt = 3'd0;
    end
    st_next.phase = tail.phase;

    tail_bytes = (tail.v && tail.kind == jsu_pkg::KIND_BYTE) ? 3'd1 : 3'd0;
    len_done   = sat_add(len, pre.n);
    len_next   = open_quote ? '0 : sat_add(len, pre.n + tail_bytes);
    len_wide   = 32'(len_done);

    bundle = '0;
    bundle.cnt = pre.n + {2'b00, tail.v};
    for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
      bundle.kinds[i] = jsu_pkg::KIND_BYTE;
      bundle.bytes[i] = pre.b[i];
      if (tail.v && pre.n == 3'(i)) begin
        bundle.kinds[i] = tail.kind;
        bundle.bytes[i] = tail.data;
      end
    end
    bundle.len = len_wide[15:0];
    bundle.err = tail.err;
  end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for json_string_unescape_utf8. A short table of text bytes covers
// the edge cases first. Random JSON string literals follow, mostly well formed
// with some broken ones mixed in. Every result is checked in order against a
// typed result or the decoder model kept here. Both handshakes idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int LEN_W      = 16;
  localparam int N_ITEMS    = 420;
  localparam int TAIL_ITEMS = 60;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] len;
    logic [1:0]  err;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    result_t    want;
  } stim_t;

  localparam result_t     NO_WANT = '0;
  localparam logic [31:0] LEN_SAT = (32'd1 << LEN_W) - 32'd1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] string_length;
  logic [1:0]  error_code;
  logic        last_of_run;

  json_string_unescape_utf8 #(.LENGTH_WIDTH(LEN_W)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_byte(char_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .out_byte(out_byte),
    .string_length(string_length),
    .error_code(error_code),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed text; results are typed in where they are obvious
  stim_t dir_tab [27] = '{
    {jsu_pkg::CH_NUL, 1'b1, jsu_pkg::KIND_ERROR, 8'h00, 16'd0, jsu_pkg::ERR_NO_QUOTE, 1'b1},
    {jsu_pkg::CH_QUOTE, 1'b0, NO_WANT},
    {8'hff, 1'b1, jsu_pkg::KIND_BYTE, 8'hff, 16'd0, 2'd0, 1'b1},
    // high surrogate whose last two digits are not hex
    {jsu_pkg::CH_BSL,   1'b0, NO_WANT},
    {jsu_pkg::CH_U,     1'b0, NO_WANT},
    {"d",               1'b0, NO_WANT},
    {"B",               1'b0, NO_WANT},
    {"g",               1'b0, NO_WANT},
    {jsu_pkg::CH_QUOTE, 1'b0, NO_WANT},
    // low half below the low surrogate range, joined anyway
    {jsu_pkg::CH_BSL,   1'b0, NO_WANT},
    {jsu_pkg::CH_U,     1'b0, NO_WANT},
    {"0",               1'b0, NO_WANT},
    {"0",               1'b0, NO_WANT},
    {"0",               1'b0, NO_WANT},
    {"0",               1'b0, NO_WANT},
    // lone high surrogate, then a plain byte
    {jsu_pkg::CH_BSL,   1'b0, NO_WANT},
    {jsu_pkg::CH_U,     1'b0, NO_WANT},
    {"D",               1'b0, NO_WANT},
    {"8",               1'b0, NO_WANT},
    {"0",               1'b0, NO_WANT},
    {"0",               1'b0, NO_WANT},
    {8'h01,             1'b0, NO_WANT},
    {jsu_pkg::CH_QUOTE, 1'b0, NO_WANT},
    {"x", 1'b1, jsu_pkg::KIND_ERROR, 8'h00, 16'd0, jsu_pkg::ERR_NO_QUOTE, 1'b1},
    // text ends right after a backslash
    {jsu_pkg::CH_QUOTE, 1'b0, NO_WANT},
    {jsu_pkg::CH_BSL,   1'b0, NO_WANT},
    {jsu_pkg::CH_NUL, 1'b1, jsu_pkg::KIND_ERROR, 8'h00, 16'd0, jsu_pkg::ERR_BAD_ESCAPE, 1'b1}
  };

  logic [7:0] esc_set [8] = '{"n", "t", "r", "b", "f",
                              jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL};

  stim_t   stim_q[$];
  result_t due_q[$];
  result_t step_out[$];
  int      in_taken    = 0;
  int      fail_cnt    = 0;
  int      quiet_cycles = 0;
  int      stall_left  = 0;
  int      rx_calm     = 0;
  bit      tail_quiet  = 1'b0;

  // decoder model state
  jsu_pkg::phase_t ph;
  logic [15:0]     code_acc;
  logic [15:0]     hi_surr;
  logic [2:0]      digit_cnt;
  logic [31:0]     byte_total;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    step_out.push_back({jsu_pkg::KIND_BYTE, b, 16'd0, 2'd0, 1'b0});
    if (byte_total < LEN_SAT) byte_total = byte_total + 32'd1;
  endfunction

  function automatic void put_error(input logic [1:0] code);
    step_out.push_back({jsu_pkg::KIND_ERROR, 8'h00, 16'd0, code, 1'b0});
    ph = jsu_pkg::PH_IDLE;
  endfunction

  function automatic void put_utf8(input logic [31:0] cp);
    if (cp < 32'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 32'h800) begin
      put_byte(8'hc0 | {3'd0, cp[10:6]});
      put_byte(8'h80 | {2'd0, cp[5:0]});
    end else if (cp < 32'h10000) begin
      put_byte(8'he0 | {4'd0, cp[15:12]});
      put_byte(8'h80 | {2'd0, cp[11:6]});
      put_byte(8'h80 | {2'd0, cp[5:0]});
    end else begin
      // lead byte keeps only its low 8 bits
      put_byte(8'hf0 | cp[25:18]);
      put_byte(8'h80 | {2'd0, cp[17:12]});
      put_byte(8'h80 | {2'd0, cp[11:6]});
      put_byte(8'h80 | {2'd0, cp[5:0]});
    end
  endfunction

  function automatic void body_char(input logic [7:0] c);
    if (c == jsu_pkg::CH_NUL) begin
      put_error(jsu_pkg::ERR_EARLY_END);
    end else if (c == jsu_pkg::CH_QUOTE) begin
      step_out.push_back({jsu_pkg::KIND_DONE, 8'h00, byte_total[15:0], 2'd0, 1'b0});
      ph = jsu_pkg::PH_IDLE;
    end else if (c == jsu_pkg::CH_BSL) begin
      ph = jsu_pkg::PH_ESC;
    end else begin
      put_byte(c);
    end
  endfunction

  function automatic void esc_char(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      "n":               v = 8'h0a;
      "t":               v = 8'h09;
      "r":               v = 8'h0d;
      "b":               v = 8'h08;
      "f":               v = 8'h0c;
      jsu_pkg::CH_SLASH: v = jsu_pkg::CH_SLASH;
      jsu_pkg::CH_QUOTE: v = jsu_pkg::CH_QUOTE;
      jsu_pkg::CH_BSL:   v = jsu_pkg::CH_BSL;
      jsu_pkg::CH_U: begin
        code_acc = '0;
        digit_cnt = '0;
        ph = jsu_pkg::PH_HEX;
        return;
      end
      default: begin
        put_error(jsu_pkg::ERR_BAD_ESCAPE);
        return;
      end
    endcase
    put_byte(v);
    ph = jsu_pkg::PH_BODY;
  endfunction

  // all results one text byte causes, last flag not yet set
  function automatic void decode_char(input logic [7:0] c);
    logic [31:0] cp;
    step_out.delete();
    case (ph)
      jsu_pkg::PH_IDLE: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          byte_total = '0;
          code_acc = '0;
          hi_surr = '0;
          digit_cnt = '0;
          ph = jsu_pkg::PH_BODY;
        end else begin
          put_error(jsu_pkg::ERR_NO_QUOTE);
        end
      end
      jsu_pkg::PH_BODY: body_char(c);
      jsu_pkg::PH_ESC:  esc_char(c);
      jsu_pkg::PH_HEX, jsu_pkg::PH_LOHEX: begin
        if (c == jsu_pkg::CH_NUL) begin
          put_error(jsu_pkg::ERR_EARLY_END);
        end else begin
          code_acc = {code_acc[11:0], hex_val(c)};
          digit_cnt = digit_cnt + 3'd1;
          if (digit_cnt == 3'd4) begin
            digit_cnt = '0;
            if (ph == jsu_pkg::PH_LOHEX) begin
              cp = 32'h10000
                   + (({16'd0, hi_surr} - {16'd0, jsu_pkg::SURR_HIGH_LO}) << 10)
                   + ({16'd0, code_acc} - {16'd0, jsu_pkg::SURR_LOW_LO});
              put_utf8(cp);
              ph = jsu_pkg::PH_BODY;
            end else if (code_acc >= jsu_pkg::SURR_HIGH_LO &&
                         code_acc < jsu_pkg::SURR_LOW_LO) begin
              hi_surr = code_acc;
              ph = jsu_pkg::PH_SURR_WAIT;
            end else begin
              put_utf8({16'd0, code_acc});
              ph = jsu_pkg::PH_BODY;
            end
          end
        end
      end
      jsu_pkg::PH_SURR_WAIT: begin
        if (c == jsu_pkg::CH_BSL) begin
          ph = jsu_pkg::PH_SURR_U;
        end else begin
          put_utf8({16'd0, hi_surr});
          ph = jsu_pkg::PH_BODY;
          body_char(c);
        end
      end
      jsu_pkg::PH_SURR_U: begin
        if (c == jsu_pkg::CH_U) begin
          code_acc = '0;
          digit_cnt = '0;
          ph = jsu_pkg::PH_LOHEX;
        end else begin
          put_utf8({16'd0, hi_surr});
          ph = jsu_pkg::PH_ESC;
          esc_char(c);
        end
      end
      default: begin
        ph = jsu_pkg::PH_IDLE;
        put_error(jsu_pkg::ERR_NO_QUOTE);
      end
    endcase
  endfunction

  // ---- random text ----

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return {4'h3, nib};
    return {($urandom_range(0, 1) ? 4'h6 : 4'h4), nib - 4'd9};
  endfunction

  function automatic void push_ch(input logic [7:0] c);
    stim_q.push_back({c, 1'b0, NO_WANT});
  endfunction

  // backslash u and four digits; with junk set any digit may be a non-hex byte
  function automatic void push_u(input logic [15:0] v, input bit junk);
    logic [7:0] c;
    push_ch(jsu_pkg::CH_BSL);
    push_ch(jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) begin
      if (junk && $urandom_range(0, 2) == 0) begin
        do c = 8'($urandom_range(1, 255));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
        push_ch(c);
      end else begin
        push_ch(hex_char(v[4*i +: 4]));
      end
    end
  endfunction

  function automatic void add_token(output bit ended);
    int          sel;
    int          k;
    logic [15:0] v;
    logic [7:0]  c;
    ended = 1'b0;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      push_ch(plain_char());
    end else if (sel < 58) begin
      push_ch(jsu_pkg::CH_BSL);
      push_ch(esc_set[$urandom_range(0, 7)]);
    end else if (sel < 73) begin
      case ($urandom_range(0, 2))
        0: v = 16'($urandom_range(0, 16'h7f));
        1: v = 16'($urandom_range(16'h80, 16'h7ff));
        default: begin
          do v = 16'($urandom_range(16'h800, 16'hffff));
          while (v >= jsu_pkg::SURR_HIGH_LO && v < jsu_pkg::SURR_LOW_LO);
        end
      endcase
      push_u(v, 1'b0);
    end else if (sel < 82) begin
      // surrogate pair, now and then with a low half out of range
      push_u(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
      if ($urandom_range(0, 3) == 0) push_u(16'($urandom_range(0, 16'hffff)), 1'b0);
      else push_u(16'($urandom_range(16'hdc00, 16'hdfff)), 1'b0);
    end else if (sel < 89) begin
      // lone high surrogate
      push_u(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
      case ($urandom_range(0, 2))
        0: push_ch(plain_char());
        1: begin
          push_ch(jsu_pkg::CH_BSL);
          push_ch(esc_set[$urandom_range(0, 7)]);
        end
        default: begin
          push_ch(jsu_pkg::CH_QUOTE);
          ended = 1'b1;
        end
      endcase
    end else if (sel < 94) begin
      push_u(16'($urandom_range(0, 16'hffff)), 1'b1);
    end else if (sel < 97) begin
      do c = 8'($urandom_range(0, 255));
      while (c == jsu_pkg::CH_U || c == "n" || c == "t" || c == "r" || c == "b" ||
             c == "f" || c == jsu_pkg::CH_SLASH || c == jsu_pkg::CH_QUOTE ||
             c == jsu_pkg::CH_BSL);
      push_ch(jsu_pkg::CH_BSL);
      push_ch(c);
      ended = 1'b1;
    end else begin
      // text ends among the hex digits
      push_ch(jsu_pkg::CH_BSL);
      push_ch(jsu_pkg::CH_U);
      k = $urandom_range(0, 3);
      repeat (k) push_ch(hex_char(4'($urandom_range(0, 15))));
      push_ch(jsu_pkg::CH_NUL);
      ended = 1'b1;
    end
  endfunction

  function automatic void add_string();
    int ntok;
    bit ended;
    if ($urandom_range(0, 15) == 0) push_ch(8'($urandom_range(0, 255)));
    push_ch(jsu_pkg::CH_QUOTE);
    ntok = $urandom_range(0, 8);
    ended = 1'b0;
    for (int t = 0; t < ntok && !ended; t++) add_token(ended);
    if (!ended) push_ch(($urandom_range(0, 11) == 0) ? jsu_pkg::CH_NUL : jsu_pkg::CH_QUOTE);
  endfunction

  // ---- sender ----

  initial begin
    int calm_left;
    calm_left = 0;
    foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
    while (stim_q.size() < N_ITEMS) add_string();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int n = 0; n < stim_q.size(); n++) begin
      if (n >= stim_q.size() - TAIL_ITEMS) tail_quiet = 1'b1;
      if (n > 0) @(negedge clk);
      if (!tail_quiet) begin
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 29) == 0) begin
          calm_left = $urandom_range(10, 40);
        end else if ($urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 14)) @(negedge clk);
        end
      end
      in_valid <= 1'b1;
      char_byte <= stim_q[n].ch;
      do @(posedge clk); while (in_stall);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (due_q.size() != 0) @(negedge clk);
    // a byte with no result may still be in flight
    repeat (20) @(negedge clk);
    if (fail_cnt == 0 && due_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // ---- receiver stalls ----

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (tail_quiet || rx_calm != 0) begin
      out_stall <= 1'b0;
      if (rx_calm != 0) rx_calm <= rx_calm - 1;
    end else if ($urandom_range(0, 39) == 0) begin
      out_stall <= 1'b0;
      rx_calm <= $urandom_range(10, 60);
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---- prediction, checking, watchdog ----

  always @(posedge clk) begin : check_proc
    result_t got;
    result_t want;
    stim_t   cur;
    bit      moved;
    if (rst) begin
      ph = jsu_pkg::PH_IDLE;
      code_acc = '0;
      hi_surr = '0;
      digit_cnt = '0;
      byte_total = '0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        cur = stim_q[in_taken];
        in_taken++;
        decode_char(char_byte);
        if (cur.typed) begin
          due_q.push_back(cur.want);
        end else begin
          for (int i = 0; i < step_out.size(); i++) begin
            want = step_out[i];
            want.last = (i == step_out.size() - 1);
            due_q.push_back(want);
          end
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got = {kind, out_byte, string_length, error_code, last_of_run};
        if (due_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: kind=%0d byte=%02h len=%0d err=%0d last=%0d",
                     got.kind, got.data, got.len, got.err, got.last);
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: want kind=%0d byte=%02h len=%0d err=%0d last=%0d, %s",
                       want.kind, want.data, want.len, want.err, want.last,
                       $sformatf("got kind=%0d byte=%02h len=%0d err=%0d last=%0d",
                                 got.kind, got.data, got.len, got.err, got.last));
          end
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
sv/jsu_pkg.sv
sv/jsu_step.sv
sv/json_string_unescape_utf8.sv
tb/sv/tb_top.sv
